// ----- src/pic_pkg.sv -----
package pic_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int IDX_BITS     = 6;
    localparam int COUNT_BITS   = 7;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int Z_W    = PROD_W + 1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam int ORIENT_LAT = 3;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } vertex_t;

    typedef struct packed
    {
        logic pos;
        logic neg;
    } sign_t;

    typedef struct packed
    {
        logic valid;
        logic last;
    } tri_tag_t;

    typedef struct packed
    {
        logic valid;
        logic last;
        logic hit;
    } tri_res_t;

endpackage

// ----- src/pic_vtx_ram.sv -----
module pic_vtx_ram
    import pic_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_BITS-1:0] waddr,
    input  vertex_t             wdata,
    input  logic                re,
    input  logic [IDX_BITS-1:0] raddr,
    output vertex_t             rdata
);

    vertex_t mem [MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/pic_orient.sv -----
module pic_orient
    import pic_pkg::*;
(
    input  logic    clk,
    input  vertex_t a,
    input  vertex_t b,
    input  vertex_t c,
    output sign_t   o
);

    logic signed [DIFF_W-1:0] dbx_reg;
    logic signed [DIFF_W-1:0] dby_reg;
    logic signed [DIFF_W-1:0] dcx_reg;
    logic signed [DIFF_W-1:0] dcy_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [Z_W-1:0]    z;
    sign_t                    o_reg;

    assign z = Z_W'(p1_reg) - Z_W'(p2_reg);
    assign o = o_reg;

    always_ff @(posedge clk)
    begin
        dbx_reg <= DIFF_W'(b.x) - DIFF_W'(a.x);
        dby_reg <= DIFF_W'(b.y) - DIFF_W'(a.y);
        dcx_reg <= DIFF_W'(c.x) - DIFF_W'(a.x);
        dcy_reg <= DIFF_W'(c.y) - DIFF_W'(a.y);
        p1_reg  <= PROD_W'(dbx_reg) * PROD_W'(dcy_reg);
        p2_reg  <= PROD_W'(dcx_reg) * PROD_W'(dby_reg);
        o_reg.neg <= z[Z_W-1];
        o_reg.pos <= !z[Z_W-1] && (z != '0);
    end

endmodule

// ----- src/pic_tri_test.sv -----
module pic_tri_test
    import pic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tri_tag_t tag,
    input  vertex_t  v0,
    input  vertex_t  vi,
    input  vertex_t  vj,
    input  vertex_t  pt,
    output tri_res_t res
);

    sign_t    o_area;
    sign_t    o_ai;
    sign_t    o_aj;
    sign_t    o_edge;
    sign_t    o_area_neg;
    tri_tag_t tag_reg [ORIENT_LAT];
    tri_res_t res_reg;
    logic     tri_hit;

    // The three orientations of the triangle's own vertices all equal the sign of
    // its area, with the middle edge reversed, so one product serves all three.
    pic_orient u_area (.clk(clk), .a(v0), .b(vi), .c(vj), .o(o_area));
    pic_orient u_ai   (.clk(clk), .a(v0), .b(vi), .c(pt), .o(o_ai));
    pic_orient u_aj   (.clk(clk), .a(v0), .b(vj), .c(pt), .o(o_aj));
    pic_orient u_edge (.clk(clk), .a(vi), .b(vj), .c(pt), .o(o_edge));

    function automatic logic agree(sign_t s1, sign_t s2);
        return !(s1.pos || s1.neg) || !(s2.pos || s2.neg)
            || (s1.pos && s2.pos) || (s1.neg && s2.neg);
    endfunction

    assign o_area_neg = '{pos: o_area.neg, neg: o_area.pos};
    assign tri_hit = agree(o_area, o_ai) && agree(o_area_neg, o_aj)
                  && agree(o_area, o_edge);
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORIENT_LAT; k++)
            begin
                tag_reg[k] <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            tag_reg[0] <= tag;
            for (int k = 1; k < ORIENT_LAT; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            res_reg.valid <= tag_reg[ORIENT_LAT-1].valid;
            res_reg.last  <= tag_reg[ORIENT_LAT-1].last;
            res_reg.hit   <= tri_hit;
        end
    end

endmodule

// ----- src/point_in_convex_polygon.sv -----
// Channel  Direction  Handshake                  Payload
// s        in         s_tvalid / s_tready        s_tuser: op; s_tdata: index, x, y
// m        out        m_tvalid / m_tready        m_tdata: inside_res
// cfg      in         cfg_valid / cfg_ready      cfg_data: vertex_count
//
// A query over n vertices (n clamped to the table size) makes one table read per
// cycle through the single memory read port, then passes the four-stage triangle
// test; fewer than three vertices skip the reads and the test. A new item is
// taken only when the previous query has placed its result in the output
// register, which may still wait for m_tready.
// Reset clears the control state and the vertex count; the table is not cleared.
module point_in_convex_polygon
    import pic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // vertex_index, coord_x, coord_y, zero pad
    input  logic                  s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // inside_res, zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_BITS-1:0] cfg_data
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_SEND
    } state_t;

    state_t                state_reg,     state_next;
    logic [IDX_BITS-1:0]   addr_reg,      addr_next;
    logic [IDX_BITS-1:0]   last_addr_reg, last_addr_next;
    logic                  rd_vld_reg,    rd_vld_next;
    logic                  rd_first_reg,  rd_first_next;
    logic                  rd_tri_reg,    rd_tri_next;
    logic                  rd_last_reg,   rd_last_next;
    vertex_t               v0_reg,        v0_next;
    vertex_t               prev_reg,      prev_next;
    vertex_t               pt_reg,        pt_next;
    logic                  hit_reg,       hit_next;
    logic                  m_valid_reg,   m_valid_next;
    logic                  m_res_reg,     m_res_next;
    logic [COUNT_BITS-1:0] count_reg,     count_next;

    logic [IDX_BITS-1:0]   in_index;
    vertex_t               in_vertex;
    op_t                   in_op;
    logic                  wr_en;
    logic                  rd_en;
    vertex_t               rd_data;
    logic [COUNT_BITS-1:0] num_vtx;
    tri_tag_t              tri_tag;
    tri_res_t              tri_res;

    assign in_index    = s_tdata[IDX_BITS-1:0];
    assign in_vertex.x = s_tdata[IDX_BITS +: COORD_BITS];
    assign in_vertex.y = s_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];
    assign in_op       = op_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W-1){1'b0}}, m_res_reg};

    assign wr_en   = s_tvalid && s_tready && (in_op == OP_WRITE);
    assign num_vtx = (count_reg > COUNT_BITS'(MAX_VERTICES)) ? COUNT_BITS'(MAX_VERTICES)
                                                             : count_reg;

    assign tri_tag.valid = rd_vld_reg && rd_tri_reg;
    assign tri_tag.last  = rd_last_reg;

    // Writes are only taken while idle, so a query's reads never meet a write.
    pic_vtx_ram u_ram
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (in_index),
        .wdata (in_vertex),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    pic_tri_test u_tri
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tri_tag),
        .v0    (v0_reg),
        .vi    (prev_reg),
        .vj    (rd_data),
        .pt    (pt_reg),
        .res   (tri_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_addr_next = last_addr_reg;
        rd_vld_next    = 1'b0;
        rd_first_next  = rd_first_reg;
        rd_tri_next    = rd_tri_reg;
        rd_last_next   = rd_last_reg;
        v0_next        = v0_reg;
        prev_next      = prev_reg;
        pt_next        = pt_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg;
        m_res_next     = m_res_reg;
        count_next     = count_reg;
        rd_en          = 1'b0;

        if (cfg_valid)
        begin
            count_next = cfg_data;
        end
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                v0_next = rd_data;
            end
            prev_next = rd_data;
        end
        if (tri_res.valid)
        begin
            hit_next = hit_reg | tri_res.hit;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (in_op == OP_QUERY))
                begin
                    pt_next        = in_vertex;
                    hit_next       = 1'b0;
                    addr_next      = '0;
                    last_addr_next = IDX_BITS'(num_vtx - COUNT_BITS'(1));
                    if (num_vtx < COUNT_BITS'(3))
                    begin
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rd_en         = 1'b1;
                rd_vld_next   = 1'b1;
                rd_first_next = (addr_reg == '0);
                rd_tri_next   = (addr_reg >= IDX_BITS'(2));
                rd_last_next  = (addr_reg == last_addr_reg);
                addr_next     = addr_reg + IDX_BITS'(1);
                if (addr_reg == last_addr_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (tri_res.valid && tri_res.last)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_res_next   = hit_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            last_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_tri_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            v0_reg        <= '0;
            prev_reg      <= '0;
            pt_reg        <= '0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_res_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            last_addr_reg <= last_addr_next;
            rd_vld_reg    <= rd_vld_next;
            rd_first_reg  <= rd_first_next;
            rd_tri_reg    <= rd_tri_next;
            rd_last_reg   <= rd_last_next;
            v0_reg        <= v0_next;
            prev_reg      <= prev_next;
            pt_reg        <= pt_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
            m_res_reg     <= m_res_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ----- test/tb_point_in_convex_polygon.sv -----
`timescale 1ns / 1ps

module tb_point_in_convex_polygon;
    import pic_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int ITEM_TARGET  = 1350;
    localparam int CALM_FROM    = 1200;

    localparam logic [1:0] ANS_OUTSIDE = 2'd0;
    localparam logic [1:0] ANS_PREDICT = 2'd2;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t              kind;
        op_t                    op;
        logic [IDX_BITS-1:0]    idx;
        logic signed [15:0]     x;
        logic signed [15:0]     y;
        logic [COUNT_BITS-1:0]  cnt;
        logic [1:0]             want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // vertex_index, coord_x, coord_y, zero pad
    logic                  s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // inside_res, zero pad
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COUNT_BITS-1:0] cfg_data;

    vertex_t               fan_vertex [MAX_VERTICES];
    logic [COUNT_BITS-1:0] fan_count;
    logic                  inside_expected_q [$];
    int                    mismatches = 0;
    int                    items_sent = 0;
    int                    idle_pct   = 0;
    int                    dead_cycles = 0;
    bit                    long_hold_done = 1'b0;
    dir_row_t              dir_tab [29];

    point_in_convex_polygon i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int orient_sign(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
        longint z;
        z = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
        return (z > 0) ? 1 : ((z < 0) ? -1 : 0);
    endfunction

    // A zero orientation on either side counts as agreement.
    function automatic bit same_side(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry, longint tx, longint ty);
        int o1;
        int o2;
        o1 = orient_sign(px, py, qx, qy, rx, ry);
        o2 = orient_sign(px, py, qx, qy, tx, ty);
        return (o1 == 0) || (o2 == 0) || (o1 == o2);
    endfunction

    function automatic bit in_fan_triangle(vertex_t a, vertex_t b, vertex_t c,
                                           longint tx, longint ty);
        longint ax = $signed(a.x);
        longint ay = $signed(a.y);
        longint bx = $signed(b.x);
        longint by = $signed(b.y);
        longint cx = $signed(c.x);
        longint cy = $signed(c.y);
        return same_side(ax, ay, bx, by, cx, cy, tx, ty) &&
               same_side(ax, ay, cx, cy, bx, by, tx, ty) &&
               same_side(bx, by, cx, cy, ax, ay, tx, ty);
    endfunction

    function automatic logic fan_hit(logic signed [15:0] px, logic signed [15:0] py);
        int n;
        n = (fan_count > MAX_VERTICES) ? MAX_VERTICES : int'(fan_count);
        for (int i = 1; i + 1 < n; i++)
        begin
            if (in_fan_triangle(fan_vertex[0], fan_vertex[i], fan_vertex[i + 1],
                                $signed(px), $signed(py)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [15:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_inside(logic got);
        logic want;
        if (inside_expected_q.size() == 0)
            report_mismatch($sformatf("inside_res %0b arrived with no query pending", got));
        else
        begin
            want = inside_expected_q.pop_front();
            if (got !== want)
                report_mismatch($sformatf("inside_res %0b, expected %0b", got, want));
        end
    endtask

    task automatic push_item(op_t op, logic [IDX_BITS-1:0] idx, logic signed [15:0] x,
                             logic signed [15:0] y, logic [1:0] want);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, y, x, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (op == OP_WRITE)
        begin
            fan_vertex[idx].x = x;
            fan_vertex[idx].y = y;
        end
        else
            inside_expected_q.push_back((want == ANS_PREDICT) ? fan_hit(x, y) : want[0]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (inside_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        fan_count = value;
    endtask

    task automatic random_item(bit query_only);
        op_t op;
        op = (query_only || $urandom_range(0, 1) == 1) ? OP_QUERY : OP_WRITE;
        push_item(op, IDX_BITS'($urandom_range(0, 63)), 16'($urandom), 16'($urandom),
                  ANS_PREDICT);
    endtask

    task automatic polygon_phase();
        logic signed [15:0] vx [MAX_VERTICES];
        logic signed [15:0] vy [MAX_VERTICES];
        int                 n;
        int                 cx;
        int                 cy;
        int                 rad;
        int                 k;
        int                 k2;
        real                ang;
        logic [COUNT_BITS-1:0] cnt;
        n  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 64) : $urandom_range(3, 10);
        cx = int'($urandom_range(0, 32000)) - 16000;
        cy = int'($urandom_range(0, 32000)) - 16000;
        case ($urandom_range(0, 2))
            0:       rad = $urandom_range(1, 20);
            1:       rad = $urandom_range(100, 3000);
            default: rad = $urandom_range(4000, 30000);
        endcase
        for (k = 0; k < n; k++)
        begin
            ang = 6.283185307179586 * (k + 0.8 * $urandom_range(0, 999) / 1000.0) / n;
            vx[k] = clamp_coord(cx + $rtoi(rad * $cos(ang)));
            vy[k] = clamp_coord(cy + $rtoi(rad * $sin(ang)));
            push_item(OP_WRITE, IDX_BITS'(k), vx[k], vy[k], ANS_PREDICT);
            if ($urandom_range(0, 9) == 0)
                random_item(1'b1);
        end
        wait_idle();
        cnt = COUNT_BITS'(n);
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 6))
                0:       cnt = 7'd0;
                1:       cnt = 7'd1;
                2:       cnt = 7'd2;
                3:       cnt = 7'd64;
                4:       cnt = 7'd65;
                5:       cnt = 7'd127;
                default: cnt = COUNT_BITS'($urandom_range(0, 127));
            endcase
        end
        write_count(cnt);
        repeat ($urandom_range(8, 24))
        begin
            k  = $urandom_range(0, n - 1);
            k2 = (k + 1) % n;
            case ($urandom_range(0, 9))
                4:
                    push_item(OP_QUERY, IDX_BITS'($urandom), vx[k], vy[k], ANS_PREDICT);
                5:
                    push_item(OP_QUERY, IDX_BITS'($urandom),
                              clamp_coord((int'(vx[k]) + int'(vx[k2])) / 2),
                              clamp_coord((int'(vy[k]) + int'(vy[k2])) / 2), ANS_PREDICT);
                6:
                    random_item(1'b1);
                7:
                    push_item(OP_QUERY, IDX_BITS'($urandom),
                              clamp_coord((int'(vx[0]) + int'(vx[k])) / 2),
                              clamp_coord((int'(vy[0]) + int'(vy[k])) / 2), ANS_PREDICT);
                8:
                    push_item(OP_WRITE, IDX_BITS'($urandom_range(0, 63)),
                              16'($urandom), 16'($urandom), ANS_PREDICT);
                default:
                    push_item(OP_QUERY, IDX_BITS'($urandom),
                              clamp_coord(cx + int'($urandom_range(0, 2 * rad)) - rad),
                              clamp_coord(cy + int'($urandom_range(0, 2 * rad)) - rad),
                              ANS_PREDICT);
            endcase
        end
    endtask

    task automatic noise_phase();
        wait_idle();
        write_count(COUNT_BITS'($urandom_range(0, 127)));
        repeat ($urandom_range(10, 30))
            random_item(1'b0);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        fan_count = '0;

        // Square, then a collinear fan, then a triangle spanning the whole coordinate range.
        dir_tab = '{
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd0,      16'sd0,      7'd0, ANS_OUTSIDE},
            '{ROW_ITEM, OP_WRITE, 6'd0,  -16'sd100,   -16'sd100,   7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd1,  16'sd100,    -16'sd100,   7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd2,  16'sd100,    16'sd100,    7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd3,  -16'sd100,   16'sd100,    7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd5,      16'sd5,      7'd0, ANS_OUTSIDE},
            '{ROW_CFG,  OP_WRITE, 6'd0,  16'sd0,      16'sd0,      7'd2, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd0,      16'sd0,      7'd0, ANS_OUTSIDE},
            '{ROW_CFG,  OP_WRITE, 6'd0,  16'sd0,      16'sd0,      7'd4, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd0,      16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd100,    16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  -16'sd100,   16'sd100,    7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd101,    16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd32767,  16'sd32767,  7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  -16'sd32768, -16'sd32768, 7'd0, ANS_PREDICT},
            '{ROW_CFG,  OP_WRITE, 6'd0,  16'sd0,      16'sd0,      7'd3, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd1,  16'sd0,      16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd2,  16'sd100,    16'sd100,    7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd32767,  -16'sd32768, 7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  -16'sd32768, 16'sd32767,  7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd63, 16'sd32767,  -16'sd32768, 7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd63, 16'sd50,     16'sd50,     7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd0,  -16'sd32768, -16'sd32768, 7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd1,  16'sd32767,  -16'sd32768, 7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_WRITE, 6'd2,  16'sd32767,  16'sd32767,  7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd0,      16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  -16'sd32768, 16'sd32767,  7'd0, ANS_PREDICT},
            '{ROW_ITEM, OP_QUERY, 6'd0,  16'sd32767,  16'sd0,      7'd0, ANS_PREDICT},
            '{ROW_CFG,  OP_WRITE, 6'd0,  16'sd0,      16'sd0,      7'd0, ANS_PREDICT}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        foreach (dir_tab[r])
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_count(dir_tab[r].cnt);
            end
            else
                push_item(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].x, dir_tab[r].y,
                          dir_tab[r].want);
        end
        push_item(OP_QUERY, 6'd0, 16'sd1, 16'sd1, ANS_OUTSIDE);

        // Every entry is written before any count that reaches it is used.
        for (int k = 0; k < MAX_VERTICES; k++)
            push_item(OP_WRITE, IDX_BITS'(k), 16'($urandom), 16'($urandom), ANS_PREDICT);
        wait_idle();
        write_count(7'd127);
        repeat (8)
            random_item(1'b1);
        wait_idle();
        write_count(7'd64);
        repeat (8)
            random_item(1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_FROM)
                idle_pct = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                noise_phase();
            else
                polygon_phase();
        end

        s_tvalid <= 1'b0;
        while (inside_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_inside(m_tdata[0]);
            if (hold_left > 0)
                hold_left--;
            else if (!long_hold_done && items_sent >= 400)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                hold_left = $urandom_range(1, 8);
            m_tready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            dead_cycles <= 0;
        else if (dead_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            dead_cycles <= dead_cycles + 1;
    end

endmodule

// ----- point_in_convex_polygon.f -----
src/pic_pkg.sv
src/pic_vtx_ram.sv
src/pic_orient.sv
src/pic_tri_test.sv
src/point_in_convex_polygon.sv
test/tb_point_in_convex_polygon.sv
